>>> rtl/plq_pkg.sv
// Package for the positional list queue: sizes, request and status codes,
// and the cell command and control result structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package plq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int POS_W  = 4;
  localparam int REQ_W  = 4;
  localparam int STAT_W = 2;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Request codes carried in s_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND      = 4'd0,
    REQ_INSERT_MID  = 4'd1,
    REQ_REMOVE_AT   = 4'd2,
    REQ_REMOVE_LAST = 4'd3,
    REQ_REMOVE_FIRST= 4'd4,
    REQ_EDIT_FIRST  = 4'd5,
    REQ_EDIT_LAST   = 4'd6,
    REQ_EDIT_MID    = 4'd7,
    REQ_READ        = 4'd8
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_POS   = 2'd3
  } stat_t;

  // Per-cycle operation applied by every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_WRITE,
    OP_SHR,
    OP_SHL
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [CNT_W-1:0]    sel;
    logic [DATA_W-1:0]   val;
  } cell_cmd_t;

  // Outcome of one request, from control to the top level
  typedef struct packed {
    stat_t               status;
    logic                rd_en;
    logic [CNT_W-1:0]    rd_sel;
    logic [CNT_W-1:0]    count;
  } ctrl_res_t;

endpackage
`default_nettype wire

>>> rtl/plq_cell.sv
// One slot of the list. Takes its neighbor's value on a shift, the broadcast
// value on a write at its own index. Depends on plq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plq_cell (
  input  wire logic                      clk,
  input  wire plq_pkg::cell_cmd_t        cmd,
  input  wire logic [plq_pkg::CNT_W-1:0] idx,
  input  wire logic [plq_pkg::DATA_W-1:0] left,
  input  wire logic [plq_pkg::DATA_W-1:0] right,
  output logic [plq_pkg::DATA_W-1:0]     data
);
  import plq_pkg::*;

  // Slot storage, no reset: contents are only read below the entry count
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_WRITE: begin
        if (idx == cmd.sel) data <= cmd.val;
      end
      OP_SHR: begin
        if (idx == cmd.sel) data <= cmd.val;
        else if (idx > cmd.sel) data <= left;
      end
      OP_SHL: begin
        if (idx >= cmd.sel) data <= right;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/plq_ctrl.sv
// Request decode and entry count for the positional list queue. Checks full,
// empty and position rules and issues the cell command. Depends on plq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plq_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic [plq_pkg::REQ_W-1:0]  req,
  input  wire logic [plq_pkg::DATA_W-1:0] val,
  input  wire logic [plq_pkg::POS_W-1:0]  pos,
  output plq_pkg::cell_cmd_t              cmd,
  output plq_pkg::ctrl_res_t              res
);
  import plq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos_x;
  logic             is_empty;
  logic             is_full;
  logic             interior;
  logic             in_range;
  cell_op_t         op;

  assign pos_x    = CNT_W'(pos);
  assign is_empty = (count == '0);
  assign is_full  = (count >= CNT_W'(DEPTH));
  assign interior = (pos_x >= CNT_W'(1)) && ((pos_x + CNT_W'(1)) < count);
  assign in_range = (pos_x < count);

  // Decode
  always_comb begin
    op         = OP_HOLD;
    cmd.sel    = pos_x;
    cmd.val    = val;
    res.status = ST_OK;
    res.rd_en  = 1'b0;
    res.rd_sel = pos_x;
    res.count  = count;
    unique case (req)
      REQ_APPEND: begin
        if (is_full) res.status = ST_FULL;
        else begin
          op        = OP_WRITE;
          cmd.sel   = count;
          res.count = count + CNT_W'(1);
        end
      end
      REQ_INSERT_MID: begin
        if (is_full) res.status = ST_FULL;
        else if (!interior) res.status = ST_POS;
        else begin
          op        = OP_SHR;
          res.count = count + CNT_W'(1);
        end
      end
      REQ_REMOVE_AT: begin
        if (is_empty) res.status = ST_EMPTY;
        else if (!in_range) res.status = ST_POS;
        else begin
          op        = OP_SHL;
          res.count = count - CNT_W'(1);
        end
      end
      REQ_REMOVE_LAST: begin
        if (is_empty) res.status = ST_EMPTY;
        else res.count = count - CNT_W'(1);
      end
      REQ_REMOVE_FIRST: begin
        if (is_empty) res.status = ST_EMPTY;
        else begin
          op        = OP_SHL;
          cmd.sel   = '0;
          res.count = count - CNT_W'(1);
        end
      end
      REQ_EDIT_FIRST: begin
        if (is_empty) res.status = ST_EMPTY;
        else begin
          op      = OP_WRITE;
          cmd.sel = '0;
        end
      end
      REQ_EDIT_LAST: begin
        if (is_empty) res.status = ST_EMPTY;
        else begin
          op      = OP_WRITE;
          cmd.sel = count - CNT_W'(1);
        end
      end
      REQ_EDIT_MID: begin
        if (is_empty) res.status = ST_EMPTY;
        else if (!interior) res.status = ST_POS;
        else op = OP_WRITE;
      end
      REQ_READ: begin
        if (is_empty) res.status = ST_EMPTY;
        else if (!in_range) res.status = ST_POS;
        else res.rd_en = 1'b1;
      end
      default: ;  // unknown request: no change
    endcase
    cmd.op = accept ? op : OP_HOLD;
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= res.count;
    end
  end

endmodule
`default_nettype wire

>>> rtl/positional_list_queue_unit.sv
// Positional list queue: packed list of DEPTH 32-bit entries with append,
// middle insert, positional remove, edits and reads. The result is registered
// in the cycle after the input transaction; one transaction per cycle unless
// m_tready stalls the output, set by the cell row updating all slots in
// parallel. Reset clears the entry count and the output valid; slot contents
// and output data are not cleared. Uses plq_pkg, plq_ctrl, plq_cell.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // value[31:0], position[35:32], zero pad
  input  wire logic [3:0]  s_tuser,   // req_type[3:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // status[1:0], read_value[33:2],
                                      // entry_count[38:34], zero pad
);
  import plq_pkg::*;

  logic                       accept;
  cell_cmd_t                  cmd;
  ctrl_res_t                  res;
  logic [DATA_W-1:0]          cell_data [DEPTH];
  logic [DATA_W-1:0]          rd_data;
  stat_t                      out_status;
  logic [DATA_W-1:0]          out_value;
  logic [CNT_W-1:0]           out_count;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  plq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (s_tuser),
    .val    (s_tdata[DATA_W-1:0]),
    .pos    (s_tdata[DATA_W+POS_W-1:DATA_W]),
    .cmd    (cmd),
    .res    (res)
  );

  // Row of slot cells, each linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    plq_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .idx   (CNT_W'(i)),
      .left  (left_d),
      .right (right_d),
      .data  (cell_data[i])
    );
  end

  // Read select: AND-OR across the cells
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (res.rd_en && (res.rd_sel == CNT_W'(k))) rd_data = rd_data | cell_data[k];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (accept) begin
      out_status <= res.status;
      out_value  <= rd_data;
      out_count  <= res.count;
    end
  end

  assign m_tdata = {1'b0, 5'(out_count), out_value, out_status};

`ifndef ASSERT_OFF
  // A full status is only reported when the list held DEPTH entries
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && (res.status == ST_FULL) |-> (u_ctrl.count == CNT_W'(DEPTH)))
    else $error("full status with room left");

  // Reported entry count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_count <= CNT_W'(DEPTH)))
    else $error("entry count beyond depth");

  // Nonzero read data only on a successful read
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_value != '0) |-> (out_status == ST_OK))
    else $error("read data with failing status");

  // Entry count holds without a transaction (a transaction moves it by at most one)
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(u_ctrl.count))
    else $error("entry count changed without a transaction");
`endif

endmodule
`default_nettype wire

>>> tb/positional_list_queue_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for positional_list_queue_unit: streams list requests, predicts
// each result from a private copy of the list (typed rows: from the table)
// and checks the result stream. Depends on plq_pkg and the unit's RTL.
module positional_list_queue_unit_tb;
  import plq_pkg::*;

  // Request codes the unit ignores
  localparam logic [REQ_W-1:0] REQ_RSVD_LO = 4'd9;
  localparam logic [REQ_W-1:0] REQ_RSVD_HI = 4'd15;

  localparam int RAND_ITEMS     = 750;
  localparam int PHASES         = 3;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    stat_t             status;
    logic [DATA_W-1:0] rd_val;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [DATA_W-1:0] val;
    logic [POS_W-1:0]  pos;
    bit                typed;
    list_result_t      res;
  } dir_row_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} traffic_mix_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // value[31:0], position[35:32], zero pad
  logic [3:0]  s_tuser;   // req_type[3:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // status[1:0], read_value[33:2], entry_count[38:34], zero pad

  // Typed expectation travelling with the current input transaction
  logic         cur_typed;
  list_result_t cur_expect;

  // Private copy of the list
  logic [DATA_W-1:0] shadow_slots [DEPTH];
  int unsigned       shadow_count;

  list_result_t pending_results [$];
  dir_row_t     dir_rows [$];

  int  mismatches  = 0;
  int  idle_cycles = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  rx_hold_req = 1'b0;

  positional_list_queue_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one request to the private list and return its result
  function automatic list_result_t predict_list_op(logic [REQ_W-1:0] req,
                                                   logic [DATA_W-1:0] val,
                                                   logic [POS_W-1:0] pos);
    list_result_t r;
    int unsigned  i;
    bit           interior;
    interior = (pos >= 1) && (pos + 1 < shadow_count);
    r.status = ST_OK;
    r.rd_val = '0;
    case (req)
      REQ_APPEND: begin
        if (shadow_count >= DEPTH) r.status = ST_FULL;
        else begin
          shadow_slots[shadow_count] = val;
          shadow_count++;
        end
      end
      REQ_INSERT_MID: begin
        if (shadow_count >= DEPTH) r.status = ST_FULL;
        else if (!interior) r.status = ST_POS;
        else begin
          for (i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[pos] = val;
          shadow_count++;
        end
      end
      REQ_REMOVE_AT, REQ_REMOVE_FIRST: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else if (req == REQ_REMOVE_AT && pos >= shadow_count) r.status = ST_POS;
        else begin
          // close the gap: later entries move one slot left
          for (i = (req == REQ_REMOVE_AT) ? pos : 0; i + 1 < shadow_count; i++)
            shadow_slots[i] = shadow_slots[i+1];
          shadow_count--;
        end
      end
      REQ_REMOVE_LAST: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count--;
      end
      REQ_EDIT_FIRST: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_slots[0] = val;
      end
      REQ_EDIT_LAST: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_slots[shadow_count-1] = val;
      end
      REQ_EDIT_MID: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else if (!interior) r.status = ST_POS;
        else shadow_slots[pos] = val;
      end
      REQ_READ: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else if (pos >= shadow_count) r.status = ST_POS;
        else r.rd_val = shadow_slots[pos];
      end
      default: ;
    endcase
    r.count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic add_row(logic [REQ_W-1:0] req, logic [DATA_W-1:0] val,
                         logic [POS_W-1:0] pos, bit typed, stat_t st,
                         logic [DATA_W-1:0] rd, logic [CNT_W-1:0] cnt);
    dir_row_t r;
    r.req = req;
    r.val = val;
    r.pos = pos;
    r.typed = typed;
    r.res.status = st;
    r.res.rd_val = rd;
    r.res.count = cnt;
    dir_rows.push_back(r);
  endtask

  // Offer one transaction, called at a falling edge; returns at the falling
  // edge after it was accepted
  task automatic send_item(logic [REQ_W-1:0] req, logic [DATA_W-1:0] val,
                           logic [POS_W-1:0] pos, bit typed, list_result_t res);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tuser    <= req;
    s_tdata    <= {4'b0, pos, val};
    cur_typed  <= typed;
    cur_expect <= res;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [REQ_W-1:0] pick_req(traffic_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 50) return REQ_APPEND;
        if (r < 75) return REQ_INSERT_MID;
        if (r < 85) return REQ_READ;
        return REQ_W'($urandom_range(REQ_EDIT_FIRST, REQ_EDIT_MID));
      end
      MIX_DRAIN: begin
        if (r < 25) return REQ_REMOVE_AT;
        if (r < 45) return REQ_REMOVE_LAST;
        if (r < 65) return REQ_REMOVE_FIRST;
        if (r < 80) return REQ_READ;
        return REQ_W'($urandom_range(REQ_EDIT_FIRST, REQ_EDIT_MID));
      end
      default: return REQ_W'($urandom_range(REQ_APPEND, REQ_READ));
    endcase
  endfunction

  // Mostly positions near the occupied range, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_pos();
    if (shadow_count > 0 && $urandom_range(0, 99) < 75)
      return POS_W'($urandom_range(0, (shadow_count > 15) ? 15 : shadow_count));
    return POS_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 39))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Predict every accepted input transaction
  always @(posedge clk) begin
    list_result_t p;
    if (!rst && s_tvalid && s_tready) begin
      p = predict_list_op(s_tuser, s_tdata[31:0], s_tdata[35:32]);
      pending_results.push_back(cur_typed ? cur_expect : p);
    end
  end

  // Check every accepted output transaction against the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = stat_t'(m_tdata[1:0]);
      got.rd_val = m_tdata[33:2];
      got.count  = m_tdata[38:34];
      if (pending_results.size() == 0) begin
        flag_error("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          flag_error($sformatf("status: expected %0d, got %0d", want.status, got.status));
        if (got.rd_val !== want.rd_val)
          flag_error($sformatf("read_value: expected %h, got %h", want.rd_val, got.rd_val));
        if (got.count !== want.count)
          flag_error($sformatf("entry_count: expected %0d, got %0d", want.count, got.count));
      end
    end
  end

  // Watchdog: cycles without any transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Stimulus
  initial begin
    int           i;
    int           ph;
    int           sent;
    int           burst_left;
    traffic_mix_t mix;
    logic [REQ_W-1:0] req;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    cur_typed  = 1'b0;
    cur_expect = '0;
    shadow_count = 0;
    burst_left = 0;
    mix = MIX_ANY;

    // Directed table; typed results only where obvious
    add_row(REQ_READ,         32'h0,         4'd0,  1, ST_EMPTY, 32'h0, 5'd0);
    add_row(REQ_REMOVE_LAST,  32'h0,         4'd0,  1, ST_EMPTY, 32'h0, 5'd0);
    add_row(REQ_REMOVE_FIRST, 32'h0,         4'd0,  1, ST_EMPTY, 32'h0, 5'd0);
    add_row(REQ_REMOVE_AT,    32'h0,         4'd0,  1, ST_EMPTY, 32'h0, 5'd0);
    add_row(REQ_EDIT_FIRST,   32'h1,         4'd0,  1, ST_EMPTY, 32'h0, 5'd0);
    add_row(REQ_EDIT_LAST,    32'h2,         4'd0,  1, ST_EMPTY, 32'h0, 5'd0);
    add_row(REQ_EDIT_MID,     32'h3,         4'd15, 1, ST_EMPTY, 32'h0, 5'd0);
    add_row(REQ_INSERT_MID,   32'h4,         4'd1,  1, ST_POS,   32'h0, 5'd0);
    add_row(REQ_APPEND,       32'h8000_0000, 4'd0,  1, ST_OK,    32'h0, 5'd1);
    add_row(REQ_READ,         32'h0,         4'd0,  1, ST_OK,    32'h8000_0000, 5'd1);
    add_row(REQ_APPEND,       32'h7FFF_FFFF, 4'd0,  1, ST_OK,    32'h0, 5'd2);
    add_row(REQ_INSERT_MID,   32'h5,         4'd1,  1, ST_POS,   32'h0, 5'd2);
    add_row(REQ_APPEND,       32'hFFFF_FFFF, 4'd15, 1, ST_OK,    32'h0, 5'd3);
    add_row(REQ_INSERT_MID,   32'h1234_5678, 4'd1,  0, ST_OK,    32'h0, 5'd0);
    add_row(REQ_EDIT_MID,     32'h6,         4'd0,  1, ST_POS,   32'h0, 5'd4);
    add_row(REQ_EDIT_MID,     32'h7,         4'd3,  1, ST_POS,   32'h0, 5'd4);
    add_row(REQ_INSERT_MID,   32'h8,         4'd3,  1, ST_POS,   32'h0, 5'd4);
    add_row(REQ_READ,         32'h0,         4'd15, 1, ST_POS,   32'h0, 5'd4);
    add_row(REQ_REMOVE_AT,    32'h0,         4'd4,  1, ST_POS,   32'h0, 5'd4);
    add_row(REQ_RSVD_HI,      32'hFFFF_FFFF, 4'd15, 1, ST_OK,    32'h0, 5'd4);
    add_row(REQ_EDIT_MID,     32'h0,         4'd2,  0, ST_OK,    32'h0, 5'd0);
    add_row(REQ_EDIT_FIRST,   32'hA5A5_A5A5, 4'd0,  0, ST_OK,    32'h0, 5'd0);
    add_row(REQ_EDIT_LAST,    32'h5A5A_5A5A, 4'd0,  0, ST_OK,    32'h0, 5'd0);
    add_row(REQ_READ,         32'h0,         4'd3,  0, ST_OK,    32'h0, 5'd0);
    add_row(REQ_REMOVE_AT,    32'h0,         4'd1,  0, ST_OK,    32'h0, 5'd0);
    add_row(REQ_REMOVE_FIRST, 32'h0,         4'd0,  0, ST_OK,    32'h0, 5'd0);
    add_row(REQ_REMOVE_LAST,  32'h0,         4'd0,  0, ST_OK,    32'h0, 5'd0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle_pct = 7;
    rx_idle_pct = 49;
    for (i = 0; i < dir_rows.size(); i++)
      send_item(dir_rows[i].req, dir_rows[i].val, dir_rows[i].pos,
                dir_rows[i].typed, dir_rows[i].res);

    // Random traffic in bursts of fill, drain or mixed requests
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 7;
          rx_idle_pct = 49;
          rx_hold_req = 1'b1;
        end
        1: begin
          tx_idle_pct = 49;
          rx_idle_pct = 7;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < RAND_ITEMS / PHASES) begin
        if (burst_left == 0) begin
          mix = traffic_mix_t'($urandom_range(0, 2));
          burst_left = $urandom_range(8, 40);
        end
        burst_left--;
        if ($urandom_range(0, 99) < 3) begin
          req = REQ_W'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
        end else begin
          req = pick_req(mix);
          sent++;
        end
        send_item(req, pick_value(), pick_pos(), 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then watch for stray ones
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/plq_pkg.sv
rtl/plq_cell.sv
rtl/plq_ctrl.sv
rtl/positional_list_queue_unit.sv
tb/positional_list_queue_unit_tb.sv
